// ----- hdl/bkc_pkg.sv -----
package bkc_pkg;

    localparam int WORD_W     = 64;
    localparam int LABEL_W    = 7;
    localparam int CNT_W      = 5;
    localparam int DIST_W     = 13;
    localparam int LANE_W     = 8;
    localparam int LANES      = WORD_W / LANE_W;
    localparam int LANE_CNT_W = $clog2(LANE_W + 1);
    localparam int SUM_W      = $clog2(WORD_W + 1);
    localparam int S_TDATA_W  = 72;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 24;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic FUNC_QUERY = 1'b0;
    localparam logic FUNC_TRAIN = 1'b1;

    // one accepted item, as it leaves the input stage
    typedef struct packed {
        logic               valid;
        logic               train;
        logic               in_range;
        logic               last_word;
        logic               last_sample;
        logic [LABEL_W-1:0] label;
    } t_word_ctl;

    // command from the distance stage to the neighbor list
    typedef struct packed {
        logic               ins;
        logic               clr;
        logic               vote;
        logic [DIST_W-1:0]  distance;
        logic [LABEL_W-1:0] label;
    } t_ins_cmd;

    // packed so that label lands in the low bits of tdata
    typedef struct packed {
        logic [CNT_W-1:0]   used;
        logic [CNT_W-1:0]   votes;
        logic [LABEL_W-1:0] label;
    } t_vote_res;

endpackage

// ----- hdl/bkc_ram.sv -----
module bkc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/bkc_dist.sv -----
module bkc_dist (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bkc_pkg::t_word_ctl         i_ctl,
    input  logic [bkc_pkg::WORD_W-1:0] i_word,
    input  logic [bkc_pkg::WORD_W-1:0] i_query,
    output bkc_pkg::t_ins_cmd          o_cmd
);

    import bkc_pkg::*;

    t_word_ctl             r_ctl;
    logic [LANE_CNT_W-1:0] r_lane [LANES];
    logic [DIST_W-1:0]     r_run;
    t_ins_cmd              r_cmd;
    logic [WORD_W-1:0]     w_diff;
    logic [SUM_W-1:0]      w_sum;
    logic [DIST_W:0]       w_total;
    logic [DIST_W-1:0]     w_dist;

    assign w_diff = i_word ^ i_query;

    // lane popcounts
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            r_lane[l] <= LANE_CNT_W'($countones(w_diff[l*LANE_W +: LANE_W]));
        end
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // merge lanes and accumulate, saturating
    always_comb begin
        w_sum = '0;
        for (int l = 0; l < LANES; l++) begin
            w_sum = w_sum + SUM_W'(r_lane[l]);
        end
        if (!r_ctl.in_range) begin
            w_sum = '0;
        end
        w_total = {1'b0, r_run} + (DIST_W+1)'(w_sum);
        w_dist  = (w_total > {1'b0, DIST_MAX}) ? DIST_MAX : w_total[DIST_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
            r_cmd <= '0;
        end else begin
            r_cmd.ins  <= 1'b0;
            r_cmd.clr  <= 1'b0;
            r_cmd.vote <= 1'b0;
            if (r_ctl.valid) begin
                if (r_ctl.train) begin
                    if (r_ctl.last_word) begin
                        r_run          <= '0;
                        r_cmd.ins      <= 1'b1;
                        r_cmd.vote     <= r_ctl.last_sample;
                        r_cmd.distance <= w_dist;
                        r_cmd.label    <= r_ctl.label;
                    end else begin
                        r_run <= w_dist;
                    end
                end else if (r_ctl.last_word) begin
                    // end of query: fresh list
                    r_run     <= '0;
                    r_cmd.clr <= 1'b1;
                end
            end
        end
    end

    assign o_cmd = r_cmd;

endmodule

// ----- hdl/bkc_list.sv -----
module bkc_list #(
    parameter int K_MAX = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bkc_pkg::t_ins_cmd         i_cmd,
    input  logic [bkc_pkg::CNT_W-1:0] i_k,
    input  logic                      i_res_ready,
    output logic                      o_done,
    output bkc_pkg::t_vote_res        o_res
);

    import bkc_pkg::*;

    localparam int FILL_W = $clog2(K_MAX + 1);
    localparam int CMP_W  = (FILL_W > CNT_W) ? FILL_W : CNT_W;
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(K_MAX);
    localparam logic [CMP_W-1:0]  K_LIM    = CMP_W'(K_MAX);
    localparam logic [CMP_W-1:0]  OUT_LIM  = CMP_W'({CNT_W{1'b1}});

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_COUNT = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [DIST_W-1:0]  r_dist [K_MAX];
    logic [LABEL_W-1:0] r_lab  [K_MAX];
    logic [FILL_W-1:0]  r_filled;
    logic [K_MAX-1:0]   w_after;

    logic [1:0]         r_state;
    logic [FILL_W-1:0]  r_vcnt [K_MAX];
    logic [LABEL_W-1:0] r_vlab [K_MAX];
    logic [FILL_W-1:0]  r_left;
    logic [FILL_W-1:0]  r_used;
    logic [FILL_W-1:0]  r_best_votes;
    logic [LABEL_W-1:0] r_best_lab;

    logic [K_MAX-1:0]   w_match [K_MAX];
    logic [FILL_W-1:0]  w_vcnt  [K_MAX];
    logic [CMP_W-1:0]   w_k;
    logic [CMP_W-1:0]   w_fill_ext;
    logic [CMP_W-1:0]   w_used_ext;
    logic [FILL_W-1:0]  w_used;
    logic               w_better;

    // each lane: does its entry stay ahead of the new sample (ties stay ahead)
    always_comb begin
        for (int i = 0; i < K_MAX; i++) begin
            w_after[i] = (FILL_W'(i) < r_filled) && (r_dist[i] <= i_cmd.distance);
        end
    end

    for (genvar g = 0; g < K_MAX; g++) begin : g_lane
        always_ff @(posedge i_clk) begin
            if (i_cmd.ins && !w_after[g]) begin
                if (g == 0 || w_after[(g > 0) ? g - 1 : 0]) begin
                    r_dist[g] <= i_cmd.distance;
                    r_lab[g]  <= i_cmd.label;
                end else begin
                    r_dist[g] <= r_dist[(g > 0) ? g - 1 : 0];
                    r_lab[g]  <= r_lab[(g > 0) ? g - 1 : 0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
        end else if (r_state == ST_COUNT || i_cmd.clr) begin
            r_filled <= '0;
        end else if (i_cmd.ins && r_filled < FILL_MAX) begin
            r_filled <= r_filled + 1'b1;
        end
    end

    // voters and per-lane vote counts
    always_comb begin
        w_fill_ext = CMP_W'(r_filled);
        if (i_k == '0) begin
            w_k = CMP_W'(1);
        end else if (CMP_W'(i_k) > K_LIM) begin
            w_k = K_LIM;
        end else begin
            w_k = CMP_W'(i_k);
        end
        w_used_ext = (w_k < w_fill_ext) ? w_k : w_fill_ext;
        w_used     = FILL_W'(w_used_ext);
        for (int i = 0; i < K_MAX; i++) begin
            for (int j = 0; j < K_MAX; j++) begin
                w_match[i][j] = (FILL_W'(j) < w_used) && (r_lab[j] == r_lab[i]);
            end
            w_vcnt[i] = FILL_W'($countones(w_match[i]));
        end
    end

    // merge: more votes wins, equal votes go to the lower label
    assign w_better = (r_vcnt[0] > r_best_votes) ||
                      ((r_vcnt[0] == r_best_votes) && (r_vlab[0] < r_best_lab));

    for (genvar g = 0; g < K_MAX; g++) begin : g_vote
        always_ff @(posedge i_clk) begin
            if (r_state == ST_COUNT) begin
                r_vcnt[g] <= w_vcnt[g];
                r_vlab[g] <= r_lab[g];
            end else if (r_state == ST_SCAN && g < K_MAX - 1) begin
                r_vcnt[g] <= r_vcnt[(g < K_MAX - 1) ? g + 1 : g];
                r_vlab[g] <= r_vlab[(g < K_MAX - 1) ? g + 1 : g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_left       <= '0;
            r_used       <= '0;
            r_best_votes <= '0;
            r_best_lab   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd.ins && i_cmd.vote) begin
                        r_state <= ST_COUNT;
                    end
                end
                ST_COUNT: begin
                    r_used       <= w_used;
                    r_left       <= w_used;
                    r_best_votes <= '0;
                    r_best_lab   <= '0;
                    r_state      <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (r_left != '0) begin
                        if (w_better) begin
                            r_best_votes <= r_vcnt[0];
                            r_best_lab   <= r_vlab[0];
                        end
                        r_left <= r_left - 1'b1;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (i_res_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_done      = (r_state == ST_DONE) && i_res_ready;
    assign o_res.label = r_best_lab;
    assign o_res.votes = (CMP_W'(r_best_votes) > OUT_LIM) ? '1 : CNT_W'(r_best_votes);
    assign o_res.used  = (CMP_W'(r_used) > OUT_LIM) ? '1 : CNT_W'(r_used);

endmodule

// ----- hdl/binary_knn_classifier.sv -----
// Binary k-nearest-neighbor classifier. Send the query image first (tuser[0] = 0), one
// 64-pixel word per item, tlast on its final word; then send labelled training images
// (tuser[0] = 1), tlast on each image's final word and tuser[1] with tlast on the last
// sample. Each training word is XORed against the stored query word, popcounted in eight
// byte lanes and merged into a saturating Hamming distance; finished samples drop into a
// sorted list of the K_MAX nearest (ties keep the earlier sample). Image words stream at
// one item per cycle with no gaps while s_axis_tready is high. After the last sample the
// input stalls while the pipeline drains and the vote runs: the lanes count votes, then
// the merge scans one neighbor per cycle, and s_axis_tready stays low until the vote is
// done, longer while an earlier result still waits in the output register. The result
// (lowest label with the most votes) is held in an output register, so the next query
// can stream in while it waits.
module binary_knn_classifier #(
    parameter int IMAGE_WORDS = 64,
    parameter int K_MAX       = 16,
    parameter int LABEL_COUNT = 100
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [bkc_pkg::CNT_W-1:0]     i_cfg_wr_data,  // neighbour_count
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [bkc_pkg::S_TDATA_W-1:0] s_axis_tdata,   // pixel_word, sample_label
    input  logic [bkc_pkg::S_TUSER_W-1:0] s_axis_tuser,   // func, last_sample
    input  logic                          s_axis_tlast,   // last_word
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [bkc_pkg::M_TDATA_W-1:0] m_axis_tdata    // predicted_label, winning_votes,
                                                          // voters_used
);

    import bkc_pkg::*;

    localparam int POS_W  = $clog2(IMAGE_WORDS + 1);
    localparam int ADDR_W = (IMAGE_WORDS > 1) ? $clog2(IMAGE_WORDS) : 1;
    localparam logic [POS_W-1:0] POS_END   = POS_W'(IMAGE_WORDS);
    localparam logic [8:0]       LABEL_LIM = 9'(LABEL_COUNT);
    localparam logic [8:0]       LABEL_SAT = 9'(LABEL_COUNT - 1);
    localparam logic [CNT_W-1:0] K_RESET   = CNT_W'(5);

    logic [CNT_W-1:0]   r_k;
    logic               r_busy;
    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   r_qlen;
    logic [POS_W-1:0]   n_pos;
    logic [POS_W-1:0]   w_pos_inc;
    t_word_ctl          r_s1_ctl;
    t_word_ctl          n_s1_ctl;
    logic [WORD_W-1:0]  r_s1_word;
    logic [WORD_W-1:0]  w_q_word;
    logic               w_acc;
    logic               w_func;
    logic               w_last;
    logic               w_last_sample;
    logic               w_has_room;
    logic               w_trigger;
    logic [WORD_W-1:0]  w_pixel;
    logic [LABEL_W-1:0] w_label_in;
    logic [LABEL_W-1:0] w_label;
    t_ins_cmd           w_cmd;
    t_vote_res          w_res;
    logic               w_res_ready;
    logic               w_done;
    logic               r_m_valid;
    t_vote_res          r_m_res;

    assign w_pixel       = s_axis_tdata[WORD_W-1:0];
    assign w_label_in    = s_axis_tdata[WORD_W +: LABEL_W];
    assign w_func        = s_axis_tuser[0];
    assign w_last_sample = s_axis_tuser[1];
    assign w_last        = s_axis_tlast;

    assign s_axis_tready = !r_busy;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_trigger     = w_acc && (w_func == FUNC_TRAIN) && w_last && w_last_sample;

    assign w_label = ({2'b00, w_label_in} >= LABEL_LIM) ? LABEL_SAT[LABEL_W-1:0] : w_label_in;

    // word position saturates past the end of the store
    assign w_has_room = r_pos < POS_END;
    assign w_pos_inc  = w_has_room ? r_pos + 1'b1 : r_pos;

    always_comb begin
        n_pos = r_pos;
        if (w_acc) begin
            n_pos = w_last ? '0 : w_pos_inc;
        end
        n_s1_ctl.valid       = w_acc;
        n_s1_ctl.train       = (w_func == FUNC_TRAIN);
        n_s1_ctl.in_range    = r_pos < r_qlen;
        n_s1_ctl.last_word   = w_last;
        n_s1_ctl.last_sample = w_last_sample;
        n_s1_ctl.label       = w_label;
    end

    always_ff @(posedge i_clk) begin
        r_s1_word <= w_pixel;
        if (!i_rst_n) begin
            r_k      <= K_RESET;
            r_busy   <= 1'b0;
            r_pos    <= '0;
            r_qlen   <= '0;
            r_s1_ctl <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_k <= i_cfg_wr_data;
            end
            if (w_trigger) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
            r_pos    <= n_pos;
            r_s1_ctl <= n_s1_ctl;
            if (w_acc && (w_func == FUNC_QUERY) && w_last) begin
                r_qlen <= w_pos_inc;
            end
        end
    end

    bkc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (IMAGE_WORDS)
    ) u_query_ram (
        .i_clk   (i_clk),
        .i_we    (w_acc && (w_func == FUNC_QUERY) && w_has_room),
        .i_waddr (r_pos[ADDR_W-1:0]),
        .i_wdata (w_pixel),
        .i_re    (w_acc && (w_func == FUNC_TRAIN)),
        .i_raddr (r_pos[ADDR_W-1:0]),
        .o_rdata (w_q_word)
    );

    bkc_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_s1_ctl),
        .i_word  (r_s1_word),
        .i_query (w_q_word),
        .o_cmd   (w_cmd)
    );

    bkc_list #(
        .K_MAX (K_MAX)
    ) u_list (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_k         (r_k),
        .i_res_ready (w_res_ready),
        .o_done      (w_done),
        .o_res       (w_res)
    );

    // output register
    assign w_res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_m_res <= w_res;
        end
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_done) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {(M_TDATA_W - $bits(t_vote_res))'(0), r_m_res};

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import bkc_pkg::*;

    localparam int STORE_WORDS = 64;
    localparam int LIST_DEPTH  = 16;
    localparam int CLASSES     = 100;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE      = 40;

    localparam logic [WORD_W-1:0] ONES = '1;
    localparam logic [WORD_W-1:0] ZERO = '0;
    localparam logic [WORD_W-1:0] MIX  = 64'h0123_4567_89AB_CDEF;
    localparam logic [WORD_W-1:0] ALT  = 64'hAAAA_AAAA_AAAA_AAAA;

    localparam logic [CNT_W-1:0] K_STEPS [6] = '{5'd17, 5'd1, 5'd16, 5'd0, 5'd31, 5'd3};

    typedef struct packed {
        logic               func;
        logic [WORD_W-1:0]  pixels;
        logic [LABEL_W-1:0] label;
        logic               last_word;
        logic               last_sample;
    } t_word_item;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [CNT_W-1:0]   votes;
        logic [CNT_W-1:0]   used;
    } t_vote;

    typedef struct packed {
        t_word_item item;
        logic       typed;
        t_vote      want;
    } t_dir_row;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0]       i_cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;  // pixel_word, sample_label
    logic [S_TUSER_W-1:0]   s_axis_tuser  = '0;  // func, last_sample
    logic                   s_axis_tlast  = 1'b0; // last_word
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;   // predicted_label, winning_votes, voters_used

    binary_knn_classifier u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // classifier state as the block should hold it
    logic [WORD_W-1:0]  q_store   [STORE_WORDS];
    logic [6:0]         q_len;
    logic [6:0]         w_pos;
    logic [DIST_W-1:0]  run_dist;
    logic [DIST_W-1:0]  near_dist [LIST_DEPTH];
    logic [LABEL_W-1:0] near_lab  [LIST_DEPTH];
    logic [CNT_W-1:0]   n_filled;
    logic [CNT_W-1:0]   k_cfg;

    t_vote       pending_votes [$];
    int          src_idle_pct = 28;
    int          snk_idle_pct = 48;
    int unsigned items_sent   = 0;
    int unsigned votes_due    = 0;
    int unsigned votes_seen   = 0;
    int unsigned errors       = 0;
    int unsigned quiet_cycles = 0;

    t_dir_row dir_tab [20] = '{
        // training before any query: every distance is zero
        '{'{FUNC_TRAIN, ONES, 7'd3,   1'b1, 1'b1}, 1'b1, '{7'd3, 5'd1, 5'd1}},
        '{'{FUNC_QUERY, ZERO, 7'd0,   1'b0, 1'b0}, 1'b0, '0},
        '{'{FUNC_QUERY, ONES, 7'd0,   1'b1, 1'b0}, 1'b0, '0},
        '{'{FUNC_TRAIN, ONES, 7'd127, 1'b0, 1'b0}, 1'b0, '0},
        '{'{FUNC_TRAIN, ZERO, 7'd127, 1'b1, 1'b0}, 1'b0, '0},
        '{'{FUNC_TRAIN, ZERO, 7'd5,   1'b1, 1'b0}, 1'b0, '0},
        '{'{FUNC_TRAIN, ZERO, 7'd5,   1'b0, 1'b1}, 1'b0, '0},
        '{'{FUNC_TRAIN, ALT,  7'd7,   1'b1, 1'b1}, 1'b0, '0},
        // stray last_sample on a query word
        '{'{FUNC_QUERY, MIX,  7'd0,   1'b1, 1'b1}, 1'b0, '0},
        '{'{FUNC_TRAIN, MIX,  7'd10,  1'b1, 1'b0}, 1'b0, '0},
        '{'{FUNC_TRAIN, MIX,  7'd20,  1'b1, 1'b0}, 1'b0, '0},
        '{'{FUNC_TRAIN, ~MIX, 7'd30,  1'b1, 1'b0}, 1'b0, '0},
        '{'{FUNC_TRAIN, MIX,  7'd20,  1'b1, 1'b1}, 1'b1, '{7'd20, 5'd2, 5'd4}},
        // words past the query length add nothing
        '{'{FUNC_TRAIN, ~MIX, 7'd40,  1'b0, 1'b0}, 1'b0, '0},
        '{'{FUNC_TRAIN, ONES, 7'd40,  1'b0, 1'b0}, 1'b0, '0},
        '{'{FUNC_TRAIN, ZERO, 7'd40,  1'b1, 1'b1}, 1'b1, '{7'd40, 5'd1, 5'd1}},
        '{'{FUNC_QUERY, ZERO, 7'd0,   1'b1, 1'b0}, 1'b0, '0},
        '{'{FUNC_TRAIN, ZERO, 7'd99,  1'b1, 1'b0}, 1'b0, '0},
        '{'{FUNC_TRAIN, ZERO, 7'd100, 1'b1, 1'b0}, 1'b0, '0},
        '{'{FUNC_TRAIN, ZERO, 7'd0,   1'b1, 1'b1}, 1'b1, '{7'd99, 5'd2, 5'd3}}
    };

    function automatic void clear_nearest();
        for (int i = 0; i < LIST_DEPTH; i++) begin
            near_dist[i] = DIST_MAX;
            near_lab[i]  = '0;
        end
        n_filled = '0;
    endfunction

    function automatic bit knn_step(input t_word_item it, output t_vote res);
        int unsigned        sum, pos, k, used, best, best_n, j;
        int unsigned        tally [CLASSES];
        logic [LABEL_W-1:0] lab;
        res = '0;
        if (it.func == FUNC_QUERY) begin
            if (w_pos < STORE_WORDS) begin
                q_store[w_pos] = it.pixels;
                w_pos++;
            end
            if (it.last_word) begin
                q_len    = w_pos;
                w_pos    = '0;
                run_dist = '0;
                clear_nearest();
            end
            return 1'b0;
        end
        if (w_pos < STORE_WORDS) begin
            if (w_pos < q_len) begin
                sum      = run_dist + $countones(it.pixels ^ q_store[w_pos]);
                run_dist = (sum > DIST_MAX) ? DIST_MAX : DIST_W'(sum);
            end
            w_pos++;
        end
        if (!it.last_word)
            return 1'b0;

        lab = (it.label >= CLASSES) ? LABEL_W'(CLASSES - 1) : it.label;
        // ties stay behind the entries already listed
        pos = 0;
        while (pos < n_filled && near_dist[pos] <= run_dist)
            pos++;
        if (pos < LIST_DEPTH) begin
            if (n_filled < LIST_DEPTH)
                n_filled++;
            for (j = n_filled - 1; j > pos; j--) begin
                near_dist[j] = near_dist[j-1];
                near_lab[j]  = near_lab[j-1];
            end
            near_dist[pos] = run_dist;
            near_lab[pos]  = lab;
        end
        run_dist = '0;
        w_pos    = '0;
        if (!it.last_sample)
            return 1'b0;

        k    = (k_cfg < 1) ? 1 : (k_cfg > LIST_DEPTH) ? LIST_DEPTH : k_cfg;
        used = (k < n_filled) ? k : n_filled;
        for (j = 0; j < CLASSES; j++)
            tally[j] = 0;
        for (j = 0; j < used; j++)
            tally[near_lab[j] % CLASSES]++;
        best   = 0;
        best_n = 0;
        for (j = 0; j < CLASSES; j++) begin
            if (tally[j] > best_n) begin
                best_n = tally[j];
                best   = j;
            end
        end
        res.label = LABEL_W'(best);
        res.votes = CNT_W'((best_n > 31) ? 31 : best_n);
        res.used  = CNT_W'((used > 31) ? 31 : used);
        clear_nearest();
        return 1'b1;
    endfunction

    // entered and left at a falling edge
    task automatic send_word(input t_word_item it, input logic typed, input t_vote want);
        t_vote res;
        bit    fires;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, it.label, it.pixels};
        s_axis_tuser  <= {it.last_sample, it.func};
        s_axis_tlast  <= it.last_word;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        fires = knn_step(it, res);
        if (fires) begin
            pending_votes.insert(pending_votes.size(), typed ? want : res);
            votes_due++;
        end
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_votes.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        k_cfg = value;
    endtask

    function automatic logic [WORD_W-1:0] vary_word(input logic [WORD_W-1:0] base);
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return {$urandom, $urandom};
            3, 4:    return base;
            default: return base ^ (64'd1 << $urandom_range(63)) ^ (64'd1 << $urandom_range(63));
        endcase
    endfunction

    // one query (or none, keeping the old one) followed by a run of labelled samples and a vote
    task automatic run_set();
        t_word_item        it;
        int unsigned       mode, qlen, nsamp, slen, lab_top, samp_lab, i, s, w;
        logic [WORD_W-1:0] qw [72];
        mode    = $urandom_range(99);
        qlen    = (mode < 5) ? $urandom_range(64, 70) : $urandom_range(1, 6);
        nsamp   = (mode < 5) ? $urandom_range(1, 3) : $urandom_range(1, 20);
        lab_top = ($urandom_range(3) == 0) ? 127 : $urandom_range(1, 5);
        for (i = 0; i < 72; i++)
            qw[i] = vary_word({$urandom, $urandom});

        // now and then keep the old query, or send one without its final word
        if (mode < 5 || mode >= 10) begin
            for (i = 0; i < qlen; i++) begin
                it.func        = FUNC_QUERY;
                it.pixels      = qw[i];
                it.label       = LABEL_W'($urandom);
                it.last_word   = (mode >= 14 || mode < 5) && (i == qlen - 1);
                it.last_sample = ($urandom_range(9) == 0);
                send_word(it, 1'b0, '0);
            end
        end

        for (s = 0; s < nsamp; s++) begin
            slen     = ($urandom_range(4) == 0) ? $urandom_range(1, qlen + 2) : qlen;
            samp_lab = $urandom_range(lab_top);
            for (w = 0; w < slen; w++) begin
                it.func        = FUNC_TRAIN;
                it.pixels      = vary_word(qw[w]);
                it.last_word   = (w == slen - 1);
                it.label       = it.last_word ? LABEL_W'(samp_lab) : LABEL_W'($urandom);
                it.last_sample = it.last_word ? (s == nsamp - 1) : ($urandom_range(19) == 0);
                send_word(it, 1'b0, '0);
            end
        end
    endtask

    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
            (m_axis_tvalid === 1'b1 && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(posedge i_clk) begin : result_check
        t_vote got, want;
        if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
            got.label = m_axis_tdata[6:0];
            got.votes = m_axis_tdata[11:7];
            got.used  = m_axis_tdata[16:12];
            votes_seen++;
            if (pending_votes.size() == 0) begin
                $error("unexpected result: label %0d votes %0d used %0d",
                       got.label, got.votes, got.used);
                errors++;
            end else begin
                want = pending_votes.pop_front();
                if (got.label !== want.label) begin
                    $error("predicted_label: expected %0d, got %0d", want.label, got.label);
                    errors++;
                end
                if (got.votes !== want.votes) begin
                    $error("winning_votes: expected %0d, got %0d", want.votes, got.votes);
                    errors++;
                end
                if (got.used !== want.used) begin
                    $error("voters_used: expected %0d, got %0d", want.used, got.used);
                    errors++;
                end
            end
        end
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial begin
        int          seg;
        int unsigned seg_items, seg_votes, sets;
        for (int i = 0; i < STORE_WORDS; i++)
            q_store[i] = '0;
        q_len    = '0;
        w_pos    = '0;
        run_dist = '0;
        k_cfg    = 5'd5;
        clear_nearest();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[r])
            send_word(dir_tab[r].item, dir_tab[r].typed, dir_tab[r].want);

        for (seg = 0; seg < 6; seg++) begin
            drain_results();
            write_count(K_STEPS[seg]);
            src_idle_pct = (seg < 2) ? 28 : (seg < 4) ? 48 : 0;
            snk_idle_pct = (seg < 2) ? 48 : (seg < 4) ? 28 : 0;
            seg_items = items_sent + 213;
            seg_votes = votes_due + 4;
            sets      = 0;
            while (items_sent < seg_items || votes_due < seg_votes) begin
                // hold off the input until every pending vote is out
                if (sets % 3 == 2)
                    drain_results();
                run_set();
                sets++;
            end
        end
        drain_results();

        $display("Streamed %0d items (queries, training words, noise); %0d votes compared.",
                 items_sent, votes_seen);
        $display("Neighbor counts 5, 17, 1, 16, 0, 31, 3 under three stall mixes; %0d errors.",
                 errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
